### design/antialiased_line_rasterizer_top_defines.svh
// Assertion helpers for the line rasterizer.
`ifndef ANTIALIASED_LINE_RASTERIZER_TOP_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ALR_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("alr check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ALR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("alr check failed");

`endif

### design/alr_pkg.sv
`default_nettype none

package alr_pkg;

  // Which pixel the datapath puts on the result ports.
  typedef enum logic [1:0] {
    EMIT_LINE  = 2'd0,  // straight walk, full coverage
    EMIT_PAIR0 = 2'd1,  // Wu column, first pixel
    EMIT_PAIR1 = 2'd2,  // Wu column, second pixel
    EMIT_END   = 2'd3   // Wu true endpoint, full coverage
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_fix;
    logic       emit;
    logic       advance;
    emit_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wu;
    logic cnt_zero;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### design/antialiased_line_rasterizer_top.sv
// Sequence: straight lines go through setup, then one emit per pixel; Wu lines go through
//   setup, the serial divide, fixup, then the two-pixel-per-column sequencer.
// A new segment is accepted only when the controller is idle again after its last pixel.
// Reset (rst, synchronous, active high) returns the controller to idle and clears the strobe.
// Results appear one per cycle under pixel_valid; the receiver cannot stall them.
`default_nettype none

`include "antialiased_line_rasterizer_top_defines.svh"

module antialiased_line_rasterizer_top #(
  parameter int COORD_BITS = 5,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command side: a segment transfers when start is high and busy is low
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  // result side: one pixel transfer per cycle in which pixel_valid is high
  output logic                       pixel_valid,
  output logic [COORD_BITS:0]        pixel_x,
  output logic [COORD_BITS:0]        pixel_y,
  output logic [FRAC_BITS:0]         coverage,
  output logic                       last_pixel
);

  alr_pkg::ctrl_cmd_t cmd;
  alr_pkg::ctrl_sts_t sts;

  // Controller: idle -> setup -> (serial divide -> fixup -> pair0/pair1 per column)
  //             or (line walk, one pixel per step). It only issues commands and reads
  //             two status bits: Wu mode and "last column reached".
  alr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath: classifies the segment on load, divides |dminor| << FRAC_BITS by dmajor
  // once per Wu segment, then steps the minor position by that exact quotient plus a
  // remainder accumulator, so floor and fraction of y1 + k*dy/dx come out per column
  // with one add and compare. The result register stage lives here too.
  alr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .coverage    (coverage),
    .last_pixel  (last_pixel)
  );

  // An accepted segment always occupies the controller on the next cycle.
  `ALR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Nothing follows the final pixel of a segment on the next cycle.
  `ALR_ASSERT_NEXT(a_last_ends, clk, rst, pixel_valid && last_pixel, !pixel_valid)
  // An idle controller issues no pixel.
  `ALR_ASSERT_NEXT(a_idle_quiet, clk, rst, !busy, !pixel_valid)
  // A pixel that is not the last one means the segment is still in work.
  `ALR_ASSERT_SAME(a_mid_busy, clk, rst, pixel_valid && !last_pixel, busy)

endmodule

`default_nettype wire

### design/alr_ctrl.sv
`default_nettype none

module alr_ctrl #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire alr_pkg::ctrl_sts_t sts,
  output alr_pkg::ctrl_cmd_t     cmd
);

  localparam int DIV_W = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIVIDE,
    S_FIX,
    S_PAIR0,
    S_PAIR1,
    S_LINE
  } state_t;

  state_t           state;
  logic [DIV_W-1:0] div_cnt;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          div_cnt <= '0;
          state   <= sts.wu ? S_DIVIDE : S_LINE;
        end
        S_DIVIDE: begin
          if (div_cnt == DIV_W'(FRAC_BITS - 1)) begin
            state <= S_FIX;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_FIX: begin
          state <= S_PAIR0;
        end
        S_PAIR0: begin
          state <= S_PAIR1;
        end
        S_PAIR1: begin
          state <= sts.cnt_zero ? S_IDLE : S_PAIR0;
        end
        S_LINE: begin
          if (sts.cnt_zero) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = alr_pkg::EMIT_LINE;
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
      end
      S_PAIR0: begin
        cmd.emit = 1'b1;
        cmd.kind = alr_pkg::EMIT_PAIR0;
      end
      S_PAIR1: begin
        cmd.emit    = 1'b1;
        cmd.kind    = sts.cnt_zero ? alr_pkg::EMIT_END : alr_pkg::EMIT_PAIR1;
        cmd.advance = !sts.cnt_zero;
      end
      S_LINE: begin
        cmd.emit    = 1'b1;
        cmd.kind    = alr_pkg::EMIT_LINE;
        cmd.advance = !sts.cnt_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/alr_datapath.sv
`default_nettype none

module alr_datapath #(
  parameter int COORD_BITS = 5,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire alr_pkg::ctrl_cmd_t    cmd,
  output alr_pkg::ctrl_sts_t         sts,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  output logic                       pixel_valid,
  output logic [COORD_BITS:0]        pixel_x,
  output logic [COORD_BITS:0]        pixel_y,
  output logic [FRAC_BITS:0]         coverage,
  output logic                       last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam logic [FB:0] COV_FULL = {1'b1, {FB{1'b0}}};

  // ---- classification of the incoming segment ----
  logic signed [CB:0] dxs, dys;
  logic [CB:0]        ndx, ndy;
  logic [CB-1:0]      adx, ady;
  logic               steep_c, swap_c, wu_c, neg_c;
  logic [CB-1:0]      su1, sv1, su2, sv2, u1, v1, u2, v2, dmaj_c, mag_c, cnt_c;

  always_comb begin
    dxs     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dys     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    ndx     = -dxs;
    ndy     = -dys;
    adx     = dxs[CB] ? ndx[CB-1:0] : dxs[CB-1:0];
    ady     = dys[CB] ? ndy[CB-1:0] : dys[CB-1:0];
    wu_c    = !((adx == '0) || (ady == '0) || (adx == ady));
    steep_c = (ady > adx);
    cnt_c   = steep_c ? ady : adx;
    su1     = steep_c ? start_y : start_x;
    sv1     = steep_c ? start_x : start_y;
    su2     = steep_c ? end_y : end_x;
    sv2     = steep_c ? end_x : end_y;
    swap_c  = (su1 > su2);
    u1      = swap_c ? su2 : su1;
    v1      = swap_c ? sv2 : sv1;
    u2      = swap_c ? su1 : su2;
    v2      = swap_c ? sv1 : sv2;
    dmaj_c  = u2 - u1;
    neg_c   = (v2 < v1);
    mag_c   = neg_c ? (v1 - v2) : (v2 - v1);
  end

  // ---- working registers ----
  logic                 wu, steep, neg;
  logic [CB-1:0]        cnt, maj, dmaj, end_u, end_v, px, py, acc, hstep;
  logic                 xmove, xneg, ymove, yneg;
  logic [CB+FB-1:0]     pos;
  logic [CB:0]          rem;
  logic [FB-1:0]        quo;
  logic signed [FB:0]   gstep;

  // restoring divide step: (mag << FB) / dmaj, one quotient bit per cycle in which div_step is set
  logic [CB:0]          rem_dbl;
  logic                 rem_ge;
  always_comb begin
    rem_dbl = {rem[CB-1:0], 1'b0};
    rem_ge  = (rem_dbl >= {1'b0, dmaj});
  end

  // minor-axis accumulator step in units of 2^-FB
  logic [CB:0]          acc_sum;
  logic                 carry;
  logic [CB:0]          acc_red;
  logic [CB+FB-1:0]     pos_next;
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, hstep};
    carry    = (acc_sum >= {1'b0, dmaj});
    acc_red  = acc_sum - {1'b0, dmaj};
    pos_next = pos + {{(CB-1){gstep[FB]}}, gstep} + (CB+FB)'(carry);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wu    <= wu_c;
      steep <= steep_c;
      neg   <= neg_c;
      cnt   <= cnt_c;
      maj   <= u1;
      dmaj  <= dmaj_c;
      end_u <= u2;
      end_v <= v2;
      pos   <= {v1, {FB{1'b0}}};
      acc   <= '0;
      rem   <= {1'b0, mag_c};
      quo   <= '0;
      px    <= start_x;
      py    <= start_y;
      xmove <= (adx != '0);
      xneg  <= dxs[CB];
      ymove <= (ady != '0);
      yneg  <= dys[CB];
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? (rem_dbl - {1'b0, dmaj}) : rem_dbl;
      quo <= {quo[FB-2:0], rem_ge};
    end
    if (cmd.div_fix) begin
      if (!neg) begin
        gstep <= $signed({1'b0, quo});
        hstep <= rem[CB-1:0];
      end else if (rem == '0) begin
        gstep <= -$signed({1'b0, quo});
        hstep <= '0;
      end else begin
        gstep <= $signed(~{1'b0, quo});
        hstep <= dmaj - rem[CB-1:0];
      end
    end
    if (cmd.advance) begin
      cnt <= cnt - 1'b1;
      maj <= maj + 1'b1;
      pos <= pos_next;
      acc <= carry ? acc_red[CB-1:0] : acc_sum[CB-1:0];
      if (xmove) begin
        px <= xneg ? (px - 1'b1) : (px + 1'b1);
      end
      if (ymove) begin
        py <= yneg ? (py - 1'b1) : (py + 1'b1);
      end
    end
  end

  always_comb begin
    sts.wu       = wu;
    sts.cnt_zero = (cnt == '0);
  end

  // ---- result selection ----
  logic [CB:0] minor_ext, major_ext, x_c, y_c;
  logic [FB:0] cov_c;
  logic        last_c;

  always_comb begin
    major_ext = {1'b0, maj};
    minor_ext = {1'b0, pos[CB+FB-1:FB]};
    x_c       = {1'b0, px};
    y_c       = {1'b0, py};
    cov_c     = COV_FULL;
    last_c    = 1'b0;
    case (cmd.kind)
      alr_pkg::EMIT_LINE: begin
        last_c = (cnt == '0);
      end
      alr_pkg::EMIT_PAIR0: begin
        cov_c = COV_FULL - {1'b0, pos[FB-1:0]};
        x_c   = steep ? minor_ext : major_ext;
        y_c   = steep ? major_ext : minor_ext;
      end
      alr_pkg::EMIT_PAIR1: begin
        cov_c = {1'b0, pos[FB-1:0]};
        x_c   = steep ? (minor_ext + 1'b1) : major_ext;
        y_c   = steep ? major_ext : (minor_ext + 1'b1);
      end
      alr_pkg::EMIT_END: begin
        x_c    = steep ? {1'b0, end_v} : {1'b0, end_u};
        y_c    = steep ? {1'b0, end_u} : {1'b0, end_v};
        last_c = 1'b1;
      end
      default: begin
        last_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      pixel_x    <= x_c;
      pixel_y    <= y_c;
      coverage   <= cov_c;
      last_pixel <= last_c;
    end
  end

endmodule

`default_nettype wire
